### hdl/lbpd_pkg.sv
// ----------------------------------------------------------------------------
// lbpd_pkg
// shared types, codes and constants of the two-led blink pattern driver
// ----------------------------------------------------------------------------
package lbpd_pkg;

    // led drive mode
    typedef enum logic [1:0] {
        MODE_ON     = 2'd0,
        MODE_OFF    = 2'd1,
        MODE_TOGGLE = 2'd2,
        MODE_BLINK  = 2'd3
    } led_mode_t;

    // kind of input word
    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_SET  = 1'b1
    } req_kind_t;

    // led numbers carried by a set-mode command
    localparam logic [1:0] LED_SEL_1 = 2'd1;
    localparam logic [1:0] LED_SEL_2 = 2'd2;

    localparam int CNT_W   = 14;
    localparam int BLINK_W = 16;
    localparam int VAL_W   = 16;

    localparam logic [CNT_W-1:0]   PRD_MIN     = CNT_W'(50);
    localparam logic [CNT_W-1:0]   PRD_MAX     = CNT_W'(10000);
    localparam logic [CNT_W-1:0]   BLINK_SHORT = CNT_W'(200);
    localparam logic [CNT_W-1:0]   BLINK_LONG  = CNT_W'(500);
    localparam logic [BLINK_W-1:0] BLINK_ONE   = BLINK_W'(1);

    // per-led command, already gated by the pipeline advance
    typedef struct packed {
        logic             tick;
        logic             set_hit;
        led_mode_t        mode;
        logic [VAL_W-1:0] value;
    } lbpd_cmd_t;

    // period clamp to 50..10000 ticks
    function automatic logic [CNT_W-1:0] clamp_period(input logic [VAL_W-1:0] value);
        logic [CNT_W-1:0] res;
        if (value > VAL_W'(PRD_MAX)) begin
            res = PRD_MAX;
        end else if (value < VAL_W'(PRD_MIN)) begin
            res = PRD_MIN;
        end else begin
            res = value[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

### hdl/lbpd_led.sv
// ----------------------------------------------------------------------------
// lbpd_led
// state and update logic of one led: countdown, mode, period and blink group
// ----------------------------------------------------------------------------
module lbpd_led
    import lbpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  lbpd_cmd_t cmd,
    output logic      lit_next
);

    led_mode_t            mode_reg,   mode_next;
    logic                 lit_reg;
    logic [CNT_W-1:0]     cd_reg,     cd_next;
    logic [CNT_W-1:0]     prd_reg,    prd_next;
    logic [BLINK_W-1:0]   total_reg,  total_next;
    logic [BLINK_W-1:0]   left_reg,   left_next;

    logic [BLINK_W-1:0]   total_fix;
    logic [BLINK_W-1:0]   left_eff;
    logic [BLINK_W-1:0]   set_total;

    always_comb begin
        total_fix = (total_reg == '0) ? BLINK_ONE : total_reg;
        left_eff  = (left_reg == '0) ? total_fix : left_reg;
        set_total = (cmd.value != '0) ? cmd.value : total_reg;
        if (set_total == '0) begin
            set_total = BLINK_ONE;
        end

        mode_next  = mode_reg;
        lit_next   = lit_reg;
        cd_next    = cd_reg;
        prd_next   = prd_reg;
        total_next = total_reg;
        left_next  = left_reg;

        if (cmd.tick) begin
            if (cd_reg != '0) begin
                cd_next = cd_reg - CNT_W'(1);
            end else begin
                unique case (mode_reg)
                    MODE_ON: begin
                        lit_next = 1'b1;
                        cd_next  = prd_reg;
                    end
                    MODE_OFF: begin
                        lit_next = 1'b0;
                        cd_next  = prd_reg;
                    end
                    MODE_TOGGLE: begin
                        lit_next = ~lit_reg;
                        cd_next  = prd_reg;
                    end
                    MODE_BLINK: begin
                        if (lit_reg) begin
                            // long gap after the last flash of a group
                            cd_next    = (left_reg != '0) ? BLINK_SHORT : BLINK_LONG;
                            lit_next   = 1'b0;
                            total_next = total_fix;
                            left_next  = left_eff;
                        end else begin
                            // empty group reloads before the flash
                            if (left_reg == '0) begin
                                total_next = total_fix;
                            end
                            cd_next   = BLINK_SHORT;
                            lit_next  = 1'b1;
                            left_next = left_eff - BLINK_W'(1);
                        end
                    end
                    default: begin
                        cd_next = prd_reg;
                    end
                endcase
            end
        end else if (cmd.set_hit) begin
            mode_next = cmd.mode;
            if (cmd.mode == MODE_BLINK) begin
                total_next = set_total;
                left_next  = set_total;
            end else begin
                prd_next = clamp_period(cmd.value);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OFF;
            lit_reg   <= 1'b0;
            cd_reg    <= '0;
            prd_reg   <= PRD_MIN;
            total_reg <= '0;
            left_reg  <= '0;
        end else begin
            mode_reg  <= mode_next;
            lit_reg   <= lit_next;
            cd_reg    <= cd_next;
            prd_reg   <= prd_next;
            total_reg <= total_next;
            left_reg  <= left_next;
        end
    end

    a_cd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cd_reg <= PRD_MAX)
        else $error("countdown above maximum period");

    a_prd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (prd_reg >= PRD_MIN) && (prd_reg <= PRD_MAX))
        else $error("reload period outside clamp range");

    a_left_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= total_reg)
        else $error("blinks left exceeds blink total");

endmodule

### hdl/led_blink_pattern_driver.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_driver
// two-led driver stepping on one-millisecond ticks and set-mode commands
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                        handshake
//  s_axis    in   tuser: req_type; tdata: sel, mode, value       tvalid/tready
//  m_axis    out  tdata: led1_lit, led2_lit                      tvalid/tready
//
//  one word per cycle sustained while the result is not stalled; a word passes
//  the input register, then the led update into the result register
//  every input word gives exactly one result word holding both drive levels
//  aresetn is synchronous active low: clears the valid flags of both stages and all led state
//  a stalled result holds; the input register still takes a word while the
//  result waits, and s_axis_tready drops only when both stages are full
//
module led_blink_pattern_driver
    import lbpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,   // [0] req_type
    input  logic [23:0] s_axis_tdata,   // [1:0] led_select, [3:2] led_mode,
                                        // [19:4] period_or_blinks, [23:20] zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] led1_lit, [1] led2_lit, [7:2] zero
);

    // input register stage
    logic             in_valid_reg;
    logic             in_valid_next;
    req_kind_t        req_reg;
    logic [1:0]       sel_reg;
    led_mode_t        mode_reg;
    logic [VAL_W-1:0] val_reg;

    // result register stage
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             led1_reg;
    logic             led2_reg;

    logic             s_accept;
    logic             out_ready;
    logic             advance;

    lbpd_cmd_t        cmd1;
    lbpd_cmd_t        cmd2;
    logic             led1_next;
    logic             led2_next;

    // result slot is free when empty or being drained this cycle
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // per-led commands; unknown led numbers hit neither led
    always_comb begin
        cmd1.tick    = advance && (req_reg == REQ_TICK);
        cmd1.set_hit = advance && (req_reg == REQ_SET) && (sel_reg == LED_SEL_1);
        cmd1.mode    = mode_reg;
        cmd1.value   = val_reg;
        cmd2.tick    = cmd1.tick;
        cmd2.set_hit = advance && (req_reg == REQ_SET) && (sel_reg == LED_SEL_2);
        cmd2.mode    = mode_reg;
        cmd2.value   = val_reg;
    end

    lbpd_led u_led1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd1),
        .lit_next (led1_next)
    );

    lbpd_led u_led2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd2),
        .lit_next (led2_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg  <= req_kind_t'(s_axis_tuser);
            sel_reg  <= s_axis_tdata[1:0];
            mode_reg <= led_mode_t'(s_axis_tdata[3:2]);
            val_reg  <= s_axis_tdata[19:4];
        end
        if (advance) begin
            led1_reg <= led1_next;
            led2_reg <= led2_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, led2_reg, led1_reg};

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled while a stage is free");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not filled after advance");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

endmodule
